### rtl/sfcp_pkg.sv
// Shared types and constants for the sync frame checksum parser.
// No dependencies; compile first.
`timescale 1ns / 1ps

package sfcp_pkg;

    // Sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'hCA;

    // Header length field: bits 6..2, counted in byte pairs
    localparam int         LEN_LSB        = 2;
    localparam logic [4:0] LEN_FIELD_MASK = 5'd31;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 10;
    localparam int LEN_W   = 6;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Configuration register index, taken from paddr[2]
    localparam logic REG_EXPECTED_ADDRESS = 1'b0;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_HEADER = 3'd2,
        PH_ID     = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHK1   = 3'd5,
        PH_CHK2   = 3'd6
    } t_phase;

endpackage

### rtl/sfcp_intf.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on sfcp_pkg.
`timescale 1ns / 1ps

interface sfcp_rx_if;
    import sfcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_res_if;
    import sfcp_pkg::*;

    logic              valid;
    logic              ready;
    logic              checksum_good;
    logic [ADDR_W-1:0] frame_address;
    logic              address_match;
    logic              link_up;

    modport source (output valid, output checksum_good, output frame_address,
                    output address_match, output link_up, input ready);
    modport sink   (input valid, input checksum_good, input frame_address,
                    input address_match, input link_up, output ready);
endinterface

### rtl/sync_frame_checksum_parser.sv
// Top level of the sync frame checksum parser: input register, frame state
// machine with mod-256 Fletcher sums, result register and APB configuration port.
// Depends on sfcp_pkg and the interfaces in sfcp_intf.sv.
`timescale 1ns / 1ps

// Usage
//   i_rx  : received bytes, one transaction per byte (valid/ready).
//   o_res : one transaction per completed frame, issued on the second
//           checksum byte: checksum_good, frame_address, address_match, link_up.
//   APB   : one register at byte address 0, expected_address (10 bits).
//           Write it only while no frame is in flight.
// Throughput: one byte per cycle, unless a frame-ending byte must wait. A byte
//   is registered on acceptance and processed by the frame state machine from
//   the input register; a frame's result is then loaded into the result register.
// Stall: a waiting result is held in the output register; bytes that give
//   no result keep flowing past it. Only a frame-ending byte waits, and the
//   input register then fills and drops ready.
// Reset (i_rst_n low, synchronous): hunting for sync, sums cleared, link
//   down, expected_address 0, both channels empty.
module sync_frame_checksum_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sfcp_rx_if.sink                  i_rx,
    sfcp_res_if.source               o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [sfcp_pkg::PADDR_W-1:0] paddr,
    input  logic [sfcp_pkg::PDATA_W-1:0] pwdata,
    output logic [sfcp_pkg::PDATA_W-1:0] prdata,
    output logic                     pready
);
    import sfcp_pkg::*;

    // Configuration
    logic [ADDR_W-1:0] r_expected_address;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Frame state
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_header, n_header;
    logic [ADDR_W-1:0] r_address, n_address;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_seen, n_seen;
    logic [BYTE_W-1:0] r_sum_first, n_sum_first;
    logic [BYTE_W-1:0] r_sum_second, n_sum_second;
    logic [BYTE_W-1:0] r_recv_first, n_recv_first;
    logic              r_link, n_link;

    // Result register
    logic              r_out_valid;
    logic              r_out_good;
    logic [ADDR_W-1:0] r_out_address;
    logic              r_out_match;
    logic              r_out_link;

    logic              w_emit;
    logic              w_good;
    logic              w_match;
    logic              w_out_free;
    logic              w_process;
    logic [4:0]        w_len_field;

    // APB: always ready, one register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPECTED_ADDRESS)
                  ? {{(PDATA_W-ADDR_W){1'b0}}, r_expected_address}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_address <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_EXPECTED_ADDRESS) begin
            r_expected_address <= pwdata[ADDR_W-1:0];
        end
    end

    // Handshake: process the held byte unless it ends a frame and the
    // result register is still occupied
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_process  = r_in_valid && (!w_emit || w_out_free);
    assign i_rx.ready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    assign w_len_field = r_in_byte[LEN_LSB +: 5] & LEN_FIELD_MASK;
    assign w_good  = (r_sum_first == r_recv_first) && (r_sum_second == r_in_byte);
    assign w_match = (r_address == r_expected_address);

    // Next state of the frame parser
    always_comb begin
        n_phase      = r_phase;
        n_header     = r_header;
        n_address    = r_address;
        n_total      = r_total;
        n_seen       = r_seen;
        n_sum_first  = r_sum_first;
        n_sum_second = r_sum_second;
        n_recv_first = r_recv_first;
        n_link       = r_link;
        w_emit       = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                n_phase = (r_in_byte == SYNC_SECOND) ? PH_HEADER : PH_HUNT;
            end
            PH_HEADER: begin
                n_header     = r_in_byte;
                n_sum_first  = r_sum_first + r_in_byte;
                n_sum_second = r_sum_second + n_sum_first;
                n_seen       = '0;
                n_total      = {w_len_field, 1'b0};
                n_phase      = PH_ID;
            end
            PH_ID: begin
                n_sum_first  = r_sum_first + r_in_byte;
                n_sum_second = r_sum_second + n_sum_first;
                n_seen       = '0;
                n_address    = {r_header[1:0], r_in_byte};
                n_phase      = PH_DATA;
            end
            PH_DATA: begin
                // a zero-length frame still takes one byte here
                n_sum_first  = r_sum_first + r_in_byte;
                n_sum_second = r_sum_second + n_sum_first;
                n_seen       = r_seen + 1'b1;
                if (n_seen >= r_total) begin
                    n_phase = PH_CHK1;
                end
            end
            PH_CHK1: begin
                n_recv_first = r_in_byte;
                n_phase      = PH_CHK2;
            end
            PH_CHK2: begin
                w_emit = 1'b1;
                if (w_good) begin
                    n_link = w_match;
                end
                n_sum_first  = '0;
                n_sum_second = '0;
                n_seen       = '0;
                n_phase      = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Advance the frame state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_header     <= '0;
            r_address    <= '0;
            r_total      <= '0;
            r_seen       <= '0;
            r_sum_first  <= '0;
            r_sum_second <= '0;
            r_recv_first <= '0;
            r_link       <= 1'b0;
        end else if (w_process) begin
            r_phase      <= n_phase;
            r_header     <= n_header;
            r_address    <= n_address;
            r_total      <= n_total;
            r_seen       <= n_seen;
            r_sum_first  <= n_sum_first;
            r_sum_second <= n_sum_second;
            r_recv_first <= n_recv_first;
            r_link       <= n_link;
        end
    end

    // Result register: load on frame end, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_process && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process && w_emit) begin
            r_out_good    <= w_good;
            r_out_address <= r_address;
            r_out_match   <= w_match;
            r_out_link    <= n_link;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.checksum_good = r_out_good;
    assign o_res.frame_address = r_out_address;
    assign o_res.address_match = r_out_match;
    assign o_res.link_up       = r_out_link;

endmodule
